// ===== hdl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared constants, command codes, controller states and the per-cell control
// word for the recency-ordered chain of cache cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Width and reset value of the capacity register.
   localparam int unsigned CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 5'd16;

   // Command codes carried by a request word.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // Control word sent to each cell of the chain.
   typedef struct packed {
      logic shift;   // take the entry of the upstream neighbor
      logic kill;    // drop the valid bit of the entry taken in
   } cell_ctrl_type;

endpackage : lkvc_pkg
`default_nettype wire

// ===== hdl/lkvc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache request channel
// Valid/ready channel that carries one command word: get or put, key, value.
// ----------------------------------------------------------------------------
interface lkvc_req_if #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic signed [KEY_BITS-1:0]   key;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, command, key, value, input ready);
   modport sink   (input valid, command, key, value, output ready);
endinterface : lkvc_req_if
`default_nettype wire

// ===== hdl/lkvc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache response channel
// Valid/ready channel that carries one lookup result word: found flag, value.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if #(
   parameter int unsigned VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic signed [VALUE_BITS-1:0] read_value;

   modport source (output valid, found, read_value, input ready);
   modport sink   (input valid, found, read_value, output ready);
endinterface : lkvc_rsp_if
`default_nettype wire

// ===== hdl/lkvc_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU cache cell
// Holds one entry of the recency-ordered chain: key, data and valid bit.
// Compares its key against an incoming request and, when told to shift,
// takes the entry of its upstream neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          compare_en,
   input  wire  [KEY_BITS-1:0]          compare_key,
   input  lkvc_pkg::cell_ctrl_type      control,
   input  wire  [KEY_BITS-1:0]          up_key,
   input  wire  [VALUE_BITS-1:0]        up_data,
   input  wire                          up_valid,
   output logic [KEY_BITS-1:0]          key_out,
   output logic [VALUE_BITS-1:0]        data_out,
   output logic                         valid_out,
   output logic                         match_out
);
   import lkvc_pkg::*;

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] data_ff;
   logic                  valid_ff;
   logic                  valid_in;
   logic                  match_ff;

   // Next valid bit: follow the neighbor on a shift, dropped by a kill.
   always_comb begin
      valid_in = valid_ff;
      if (control.shift) begin
         valid_in = up_valid & ~control.kill;
      end else if (control.kill) begin
         valid_in = 1'b0;
      end
   end

   // Valid bit and the registered key match.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (compare_en) begin
            match_ff <= valid_ff && (key_ff == compare_key);
         end
      end
   end

   // Entry payload moves one cell down the chain on a shift.
   always_ff @(posedge clock) begin
      if (control.shift) begin
         key_ff  <= up_key;
         data_ff <= up_data;
      end
   end

   assign key_out   = key_ff;
   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign match_out = match_ff;

endmodule : lkvc_cell
`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store kept as a chain of cells in recency
// order, most recent first. A get answers with found and the stored value and
// moves a hit to the head; a put updates or inserts at the head, evicting the
// tail entry when the store holds capacity entries or more.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word
//  req_chan   in         command (0 get, 1 put), key, value
//  rsp_chan   out        found, read_value (one word per get, none per put)
//  csr_*      in         capacity, written when the write enable is high
//
//  Each request is accepted in the idle state: at the accepting edge every cell
//  registers the compare of its key with the request; in the update state the
//  hit is resolved and, on commit, the chain shifts by one cell toward the tail
//  up to the hit or across the whole row. Reset clears all valid bits and sets
//  the capacity to 16; no clearing pass. A get waits in the update state while
//  the previous response word is still held by a stalled consumer.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int unsigned ENTRIES    = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   lkvc_req_if.sink                         req_chan,
   lkvc_rsp_if.source                       rsp_chan,
   input  wire                              csr_write_enable,
   input  wire  [lkvc_pkg::CAP_BITS-1:0]    csr_write_data
);
   import lkvc_pkg::*;

   localparam int unsigned OCC_BITS = $clog2(ENTRIES + 1);
   localparam int unsigned CW       = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

   state_type state_ff, state_in;

   logic                  command_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CAP_BITS-1:0]   capacity_ff;
   logic [OCC_BITS-1:0]   occupancy_ff, occupancy_in;
   logic                  rsp_valid_ff;
   logic                  found_ff;
   logic [VALUE_BITS-1:0] read_value_ff;

   logic                  req_accept;
   logic                  commit;
   logic                  hit;
   logic                  put_miss;
   logic                  evict;
   logic [CW-1:0]         cap_ext;
   logic [CW-1:0]         cap_eff;
   logic [VALUE_BITS-1:0] hit_data;
   logic [VALUE_BITS-1:0] head_data;

   logic [ENTRIES-1:0]    match_vec;
   logic [ENTRIES-1:0]    at_or_above;
   logic [ENTRIES-1:0]    data_column [VALUE_BITS];
   logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
   logic [VALUE_BITS-1:0] cell_data  [ENTRIES];
   logic                  cell_valid [ENTRIES];
   cell_ctrl_type         cell_ctrl  [ENTRIES];

   assign req_accept = req_chan.valid && req_chan.ready;

   // An update completes unless a get would overwrite a waiting response.
   assign commit = (state_ff == ST_UPDATE) &&
                   !((command_ff == CMD_GET) && rsp_valid_ff && !rsp_chan.ready);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_UPDATE: req_chan.ready = 1'b0;
         default:   req_chan.ready = 1'b0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         occupancy_ff <= '0;
      end else begin
         state_ff     <= state_in;
         occupancy_ff <= occupancy_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
      end
   end

   // Request word is held for the update cycle.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         command_ff <= req_chan.command;
         key_ff     <= req_chan.key;
         value_ff   <= req_chan.value;
      end
   end

   // Effective capacity: zero counts as one, saturated at the cell count.
   always_comb begin
      cap_ext = CW'(capacity_ff);
      cap_eff = cap_ext;
      if (cap_ext == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ext > CW'(ENTRIES)) begin
         cap_eff = CW'(ENTRIES);
      end
   end

   assign hit      = |match_vec;
   assign put_miss = (command_ff == CMD_PUT) && !hit;
   assign evict    = CW'(occupancy_ff) >= cap_eff;

   // A new key grows the store until it reaches capacity.
   always_comb begin
      occupancy_in = occupancy_ff;
      if (commit && put_miss && !evict) begin
         occupancy_in = occupancy_ff + OCC_BITS'(1);
      end
   end

   // Cells at or above the hit position make room for the entry at the head.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         at_or_above[i] = |(match_vec & ({ENTRIES{1'b1}} << i));
      end
   end

   // Data of the hit cell, one OR reduction per bit.
   always_comb begin
      for (int b = 0; b < VALUE_BITS; b++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            data_column[b][i] = cell_data[i][b] & match_vec[i];
         end
      end
      for (int b = 0; b < VALUE_BITS; b++) begin
         hit_data[b] = |data_column[b];
      end
   end

   assign head_data = (command_ff == CMD_PUT) ? value_ff : hit_data;

   // Chain of cells, most recent at index zero.
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0]   up_key;
      logic [VALUE_BITS-1:0] up_data;
      logic                  up_valid;

      if (i == 0) begin : g_head
         assign up_key   = key_ff;
         assign up_data  = head_data;
         assign up_valid = 1'b1;
      end else begin : g_body
         assign up_key   = cell_key[i-1];
         assign up_data  = cell_data[i-1];
         assign up_valid = cell_valid[i-1];
      end

      assign cell_ctrl[i].shift = commit && (put_miss || (hit && at_or_above[i]));
      assign cell_ctrl[i].kill  = commit && put_miss && evict &&
                                  (OCC_BITS'(i) == occupancy_ff);

      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .compare_en  (req_accept),
         .compare_key (req_chan.key),
         .control     (cell_ctrl[i]),
         .up_key      (up_key),
         .up_data     (up_data),
         .up_valid    (up_valid),
         .key_out     (cell_key[i]),
         .data_out    (cell_data[i]),
         .valid_out   (cell_valid[i]),
         .match_out   (match_vec[i])
      );
   end

   // Response register: loaded by a completed get, freed when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit && (command_ff == CMD_GET)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && (command_ff == CMD_GET)) begin
         found_ff      <= hit;
         read_value_ff <= hit ? hit_data : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.found      = found_ff;
   assign rsp_chan.read_value = read_value_ff;

endmodule : lru_key_value_cache
`default_nettype wire

// ===== test/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put words into the cache over its request channel and checks
// every lookup word against a shadow copy of the store that tracks validity,
// keys, data and recency rank. The run starts with hand-picked corner cases
// and then sweeps a series of capacity settings with random traffic drawn
// from small key pools, under random stalls on both channels.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int unsigned SLOTS        = 16;
   localparam int unsigned CYCLE_LIMIT  = 400_000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS  = 180;

   // One expected lookup word.
   typedef struct packed {
      logic        found;
      logic [31:0] read_value;
   } lookup_word_type;

   // Shadow of the cache contents; predicts each lookup word as requests go in.
   class lru_mirror;
      bit                  held[SLOTS];
      logic [31:0]         tag[SLOTS];
      logic [31:0]         payload[SLOTS];
      int unsigned         age[SLOTS];
      int unsigned         fill;
      logic [CAP_BITS-1:0] capacity;
      lookup_word_type     pending_lookups[$];
      int unsigned         lookups, hits, stores, evictions, failures;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            held[i] = 1'b0;
            tag[i] = '0;
            payload[i] = '0;
            age[i] = i;
         end
         fill = 0;
         capacity = CAPACITY_RESET;
      endfunction

      // Zero behaves as one, and anything above the slot count saturates.
      function int unsigned capacity_in_use();
         int unsigned c;
         c = capacity;
         if (c == 0) c = 1;
         if (c > SLOTS) c = SLOTS;
         return c;
      endfunction

      // Make slot s most recent; every valid slot that was younger ages by one.
      function void promote(int s);
         int unsigned r;
         r = age[s];
         for (int i = 0; i < SLOTS; i++)
            if (held[i] && i != s && age[i] < r) age[i]++;
         age[s] = 0;
      endfunction

      function int slot_of(logic [31:0] key);
         for (int i = 0; i < SLOTS; i++)
            if (held[i] && tag[i] == key) return i;
         return -1;
      endfunction

      function void note_request(logic cmd, logic [31:0] key, logic [31:0] value);
         int              s;
         lookup_word_type word;
         s = slot_of(key);
         if (cmd == CMD_GET) begin
            lookups++;
            if (s >= 0) begin
               hits++;
               promote(s);
               word.found = 1'b1;
               word.read_value = payload[s];
            end else begin
               word.found = 1'b0;
               word.read_value = '0;
            end
            pending_lookups.push_back(word);
            return;
         end
         stores++;
         if (s >= 0) begin
            payload[s] = value;
            promote(s);
            return;
         end
         if (fill >= capacity_in_use() || fill >= SLOTS) begin
            // Replace the least recently used valid slot.
            for (int i = 0; i < SLOTS; i++)
               if (held[i] && (s < 0 || age[i] > age[s])) s = i;
            evictions++;
         end else begin
            for (int i = SLOTS - 1; i >= 0; i--)
               if (!held[i]) s = i;
            held[s] = 1'b1;
            age[s] = fill;
            fill++;
         end
         tag[s] = key;
         payload[s] = value;
         promote(s);
      endfunction

      function void check_reply(logic found, logic [31:0] read_value);
         lookup_word_type want;
         if (pending_lookups.size() == 0) begin
            $error("response word with no lookup pending: found=%0d read_value=%h",
                   found, read_value);
            failures++;
            return;
         end
         want = pending_lookups.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            failures++;
         end
         if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            failures++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [CAP_BITS-1:0] csr_write_data;

   lkvc_req_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_chan ();
   lkvc_rsp_if #(.VALUE_BITS(32))                rsp_chan ();

   lru_key_value_cache #(
      .ENTRIES(SLOTS),
      .KEY_BITS(32),
      .VALUE_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   lru_mirror   mirror = new();
   logic [31:0] key_pool[$];
   int unsigned idle_odds;     // 0 turns idling off, else one chance in idle_odds
   int unsigned stall_left;
   int unsigned cycle_count;
   int unsigned capacity_writes;

   // Clock.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Consumer side: ready drops for random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_chan.ready = 1'b0;
         stall_left = $urandom_range(1, 7) - 1;
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // Every accepted response word is checked against the oldest lookup.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         mirror.check_reply(rsp_chan.found, rsp_chan.read_value);
   end

   // Offer one request word, with an occasional gap ahead of it.
   task automatic send_request(input logic cmd, input logic [31:0] key,
                               input logic [31:0] value);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.command = cmd;
      req_chan.key = key;
      req_chan.value = value;
      do @(posedge clock); while (!req_chan.ready);
      mirror.note_request(cmd, key, value);
      @(negedge clock);
   endtask

   // Hold off until every lookup is answered and a trailing put has settled.
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (mirror.pending_lookups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      csr_write_data = cap;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      mirror.capacity = cap;
      capacity_writes++;
   endtask

   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 99) < 88)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return $urandom();
   endfunction

   // One capacity setting with random traffic over a fresh pool of keys. Some
   // pool keys differ from an earlier one in a single bit.
   task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int unsigned odds);
      int unsigned pool_size;
      logic        cmd;
      wait_drained();
      write_capacity(cap);
      idle_odds = odds;
      pool_size = mirror.capacity_in_use() + $urandom_range(1, 6);
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) begin
         if (i > 0 && $urandom_range(0, 3) == 0)
            key_pool.push_back(key_pool[$urandom_range(0, i - 1)]
                               ^ (32'h1 << $urandom_range(0, 31)));
         else
            key_pool.push_back($urandom());
      end
      repeat (PHASE_ITEMS) begin
         cmd = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
         send_request(cmd, pick_key(), $urandom());
      end
   endtask

   // Capacity plan for the random sweep; the last phase runs without idling.
   logic [CAP_BITS-1:0] cap_plan[10] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd9,
                                         5'd1, 5'd16, 5'd5, 5'd17, 5'd12};
   int unsigned odds_plan[10] = '{4, 3, 0, 2, 5, 4, 3, 2, 6, 0};

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_GET;
      req_chan.key = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      idle_odds = 3;
      stall_left = 0;
      cycle_count = 0;
      capacity_writes = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Empty store, extreme keys and values, hits, an in-place update.
      send_request(CMD_GET, 32'h8000_0000, 32'h0);
      send_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
      send_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
      send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
      send_request(CMD_GET, 32'h8000_0000, 32'hffff_ffff);
      send_request(CMD_GET, 32'h7fff_ffff, 32'h0);
      send_request(CMD_GET, 32'h0000_0000, 32'h0);
      send_request(CMD_GET, 32'hffff_ffff, 32'h0);
      send_request(CMD_PUT, 32'h7fff_ffff, 32'h1234_5678);
      send_request(CMD_GET, 32'h7fff_ffff, 32'h0);
      send_request(CMD_GET, 32'h0000_0001, 32'h0);

      // Capacity lowered to one with four entries held: each new key evicts
      // only the oldest entry.
      wait_drained();
      write_capacity(5'd1);
      send_request(CMD_PUT, 32'h0000_0055, 32'h0000_0001);
      send_request(CMD_PUT, 32'h0000_00aa, 32'h0000_0002);
      send_request(CMD_GET, 32'h0000_0055, 32'h0);
      send_request(CMD_GET, 32'h0000_00aa, 32'h0);
      send_request(CMD_GET, 32'h0000_0000, 32'h0);

      // A get refreshes recency ahead of a put that replaces the oldest entry.
      wait_drained();
      write_capacity(5'd2);
      send_request(CMD_PUT, 32'h0000_0033, 32'haaaa_5555);
      send_request(CMD_GET, 32'h0000_0055, 32'h0);
      send_request(CMD_PUT, 32'h0000_0044, 32'h5555_aaaa);
      send_request(CMD_GET, 32'h0000_0033, 32'h0);
      send_request(CMD_GET, 32'h0000_0055, 32'h0);
      send_request(CMD_GET, 32'h0000_0044, 32'h0);

      for (int p = 0; p < 10; p++)
         run_phase(cap_plan[p], odds_plan[p]);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mirror.pending_lookups.size() != 0) begin
         $error("%0d lookups never answered", mirror.pending_lookups.size());
         mirror.failures++;
      end

      $display("Covered %0d lookups (%0d hits) and %0d stores with %0d evictions,",
               mirror.lookups, mirror.hits, mirror.stores, mirror.evictions);
      $display("across %0d capacity writes from zero up to thirty-one.",
               capacity_writes);
      if (mirror.failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule : lru_key_value_cache_tb
